// File: hw/rtl/rlfr_pkg.sv
// Package for the rotating lagged Fibonacci random generator.
// Holds the shared constants, the word type, the command codes and the unit opcodes.
// No dependencies.
package rlfr_pkg;

  localparam int unsigned WordW        = 32;
  localparam int unsigned RingDepth    = 17;
  localparam int unsigned PartnerStart = 10;
  localparam int unsigned RotPartner   = 13;
  localparam int unsigned RotCurrent   = 9;
  localparam logic [WordW-1:0] LcgMult = 32'd2891336453;
  localparam logic [WordW-1:0] LcgInc  = 32'd1;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic {
    CMD_DRAW   = 1'b0,
    CMD_RESEED = 1'b1
  } cmd_e;

  typedef enum logic {
    OP_LCG = 1'b0,
    OP_MIX = 1'b1
  } alu_op_e;

endpackage

// File: hw/rtl/rlfr_alu.sv
// Shared arithmetic unit: one LCG step or the rotate-and-add mix of two ring words.
// Depends on rlfr_pkg.
module rlfr_alu (
  input  rlfr_pkg::alu_op_e op_i,
  input  rlfr_pkg::word_t   a_i,
  input  rlfr_pkg::word_t   b_i,
  output rlfr_pkg::word_t   res_o
);
  import rlfr_pkg::*;

  word_t rot_a;
  word_t rot_b;
  word_t prod;

  assign rot_a = (a_i << RotPartner) | (a_i >> (WordW - RotPartner));
  assign rot_b = (b_i << RotCurrent) | (b_i >> (WordW - RotCurrent));
  // Only the low word of the product is kept, as the generator works modulo 2^32.
  assign prod  = a_i * LcgMult;

  always_comb begin
    case (op_i)
      OP_LCG:  res_o = prod + LcgInc;
      OP_MIX:  res_o = rot_a + rot_b;
      default: res_o = rot_a + rot_b;
    endcase
  end

endmodule

// File: hw/rtl/rlfr_ring.sv
// Ring word memory: one write port, two registered read ports, per-entry valid bits.
// Depends on rlfr_pkg.
module rlfr_ring #(
  parameter int unsigned Depth = rlfr_pkg::RingDepth,
  parameter int unsigned IdxW  = $clog2(Depth)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [IdxW-1:0]   waddr_i,
  input  rlfr_pkg::word_t   wdata_i,
  input  logic [IdxW-1:0]   raddr0_i,
  input  logic [IdxW-1:0]   raddr1_i,
  output rlfr_pkg::word_t   rdata0_o,
  output rlfr_pkg::word_t   rdata1_o
);
  import rlfr_pkg::*;

  word_t            mem [Depth];
  logic [Depth-1:0] vld_q;
  word_t            rdata0_q;
  word_t            rdata1_q;
  logic             rvld0_q;
  logic             rvld1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata0_q <= mem[raddr0_i];
    rdata1_q <= mem[raddr1_i];
  end

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      rvld0_q <= 1'b0;
      rvld1_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rvld0_q <= vld_q[raddr0_i];
      rvld1_q <= vld_q[raddr1_i];
    end
  end

  assign rdata0_o = rvld0_q ? rdata0_q : '0;
  assign rdata1_o = rvld1_q ? rdata1_q : '0;

endmodule

// File: hw/rtl/rotating_lagged_fibonacci_rng_core.sv
// Rotating lagged Fibonacci (RANROT-B) random generator, top level.
// Uses rlfr_pkg, rlfr_ring and rlfr_alu.
//
// Usage: the input channel (in_valid_i / in_stall_o) carries one command per
// beat. A draw command (cmd_i = 0) returns one 32-bit word on the output
// channel (out_valid_o / out_stall_i); a reseed (cmd_i = 1) returns nothing
// and refills the 17-word ring from seed_value_i, or from the count of beats
// taken since reset when the seed is zero.
// Timing: a draw reads both ring words at the accept edge into the ring's
// read registers, mixes them in the shared unit and writes the result to the
// output register and back to the ring; the next beat is taken only once the
// draw has finished. A reseed runs the shared unit's LCG step once per ring
// word and writes each result through the ring's single write port.
// The input side is stalled while a command is in work.
// Reset restarts the indices, clears the beat count and the ring (reads return zero).
// If the receiver stalls with a result pending, that result holds and a new
// command is still taken; a following draw waits to finish until the output
// register is free.
module rotating_lagged_fibonacci_rng_core #(
  parameter int unsigned RING_DEPTH = rlfr_pkg::RingDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            cmd_i,
  input  rlfr_pkg::word_t seed_value_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output rlfr_pkg::word_t random_word_o
);
  import rlfr_pkg::*;

  localparam int unsigned IdxW = $clog2(RING_DEPTH);
  localparam logic [IdxW-1:0] LastIdx    = IdxW'(RING_DEPTH - 1);
  localparam logic [IdxW-1:0] PartnerIdx = IdxW'(PartnerStart);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DRAW = 3'b010,
    ST_SEED = 3'b100
  } state_e;

  state_e          state_q, state_d;
  logic [IdxW-1:0] cur_q, cur_d;
  logic [IdxW-1:0] par_q, par_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  word_t           count_q, count_d;
  word_t           seed_q, seed_d;
  logic            out_valid_q, out_valid_d;
  word_t           out_word_q, out_word_d;

  logic            in_acc;
  logic            out_free;
  logic            ring_we;
  logic [IdxW-1:0] ring_waddr;
  word_t           cur_word;
  word_t           par_word;
  alu_op_e         alu_op;
  word_t           alu_a;
  word_t           alu_res;

  rlfr_ring #(
    .Depth (RING_DEPTH),
    .IdxW  (IdxW)
  ) u_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .we_i     (ring_we),
    .waddr_i  (ring_waddr),
    .wdata_i  (alu_res),
    .raddr0_i (cur_q),
    .raddr1_i (par_q),
    .rdata0_o (cur_word),
    .rdata1_o (par_word)
  );

  rlfr_alu u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (cur_word),
    .res_o (alu_res)
  );

  assign in_stall_o    = (state_q != ST_IDLE);
  assign in_acc        = in_valid_i && !in_stall_o;
  assign out_free      = !out_valid_q || !out_stall_i;
  assign out_valid_o   = out_valid_q;
  assign random_word_o = out_word_q;

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    par_d       = par_q;
    cnt_d       = cnt_q;
    seed_d      = seed_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_word_d  = out_word_q;
    ring_we     = 1'b0;
    ring_waddr  = cur_q;
    alu_op      = OP_MIX;
    alu_a       = par_word;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          count_d = count_q + 1'b1;
          if (cmd_e'(cmd_i) == CMD_RESEED) begin
            seed_d  = (seed_value_i == '0) ? count_q : seed_value_i;
            cnt_d   = '0;
            state_d = ST_SEED;
          end else begin
            state_d = ST_DRAW;
          end
        end
      end
      ST_DRAW: begin
        // Ring reads were issued at the accept edge; finish once the output slot frees.
        if (out_free) begin
          ring_we     = 1'b1;
          out_valid_d = 1'b1;
          out_word_d  = alu_res;
          cur_d       = (cur_q == '0) ? LastIdx : cur_q - 1'b1;
          par_d       = (par_q == '0) ? LastIdx : par_q - 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_SEED: begin
        alu_op     = OP_LCG;
        alu_a      = seed_q;
        ring_we    = 1'b1;
        ring_waddr = cnt_q;
        seed_d     = alu_res;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == LastIdx) begin
          cur_d   = '0;
          par_d   = PartnerIdx;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_q       <= '0;
      par_q       <= PartnerIdx;
      cnt_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      par_q       <= par_d;
      cnt_q       <= cnt_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seed_q     <= seed_d;
    out_word_q <= out_word_d;
  end

endmodule

// File: tb/rotating_lagged_fibonacci_rng_core_tb.sv
// Testbench for rotating_lagged_fibonacci_rng_core: predicts every drawn word and
// compares it on the output channel under random idling and back-pressure.
// Depends on rlfr_pkg and the core RTL only.
`timescale 1ns / 100ps

module rotating_lagged_fibonacci_rng_core_tb;
  import rlfr_pkg::*;

  localparam int unsigned ClkPeriod     = 20;
  localparam int unsigned ResetCycles   = 12;
  localparam int unsigned SettleCycles  = 24;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned PhaseItems    = 480;

  logic  clk_i;
  logic  rst_ni;
  logic  in_valid_i;
  logic  in_stall_o;
  logic  cmd_i;
  word_t seed_value_i;
  logic  out_valid_o;
  logic  out_stall_i;
  word_t random_word_o;

  // Predicted generator state.
  word_t       gen_ring [RingDepth];
  logic [4:0]  gen_cur;
  logic [4:0]  gen_partner;
  word_t       gen_beats;
  word_t       expected_words [$];

  int unsigned fail_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_off_left;
  int unsigned quiet_cycles;

  rotating_lagged_fibonacci_rng_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .seed_value_i (seed_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .random_word_o(random_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  function automatic word_t rotl(word_t v, int unsigned n);
    return (v << n) | (v >> (WordW - n));
  endfunction

  function automatic logic [4:0] index_down(logic [4:0] idx);
    return (idx == 5'd0) ? 5'(RingDepth - 1) : idx - 5'd1;
  endfunction

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    $display("mismatch %s: got %08h expected %08h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // Applies one accepted beat to the predicted state; a draw queues its word.
  task automatic advance_generator(input cmd_e c, input word_t seed);
    word_t s;
    word_t w;
    if (c == CMD_RESEED) begin
      s = (seed == '0) ? gen_beats : seed;
      for (int i = 0; i < RingDepth; i++) begin
        s = s * LcgMult + LcgInc;
        gen_ring[i] = s;
      end
      gen_cur     = '0;
      gen_partner = 5'(PartnerStart);
    end else begin
      w = rotl(gen_ring[gen_partner], RotPartner) + rotl(gen_ring[gen_cur], RotCurrent);
      gen_ring[gen_cur] = w;
      gen_cur     = index_down(gen_cur);
      gen_partner = index_down(gen_partner);
      expected_words.push_back(w);
    end
    gen_beats = gen_beats + 1;
  endtask

  // Both channels are sampled here at the rising edge; the watchdog shares it.
  always @(posedge clk_i) begin
    word_t want;
    logic  moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        advance_generator(cmd_e'(cmd_i), seed_value_i);
        moved = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected beat", random_word_o, '0);
        end else begin
          want = expected_words.pop_front();
          if (random_word_o !== want) report_mismatch("random_word", random_word_o, want);
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("watchdog: no beat for %0d cycles", WatchdogLimit);
        $display("FAIL rotating_lagged_fibonacci_rng_core");
        $finish;
      end
    end
  end

  // Receiver: random stalls, or a long hold-off while hold_off_left runs down.
  always @(negedge clk_i) begin
    if (hold_off_left > 0) begin
      out_stall_i <= 1'b1;
      hold_off_left <= hold_off_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Valid stays high after acceptance so back-to-back beats need no extra edge.
  task automatic send_beat(input cmd_e c, input word_t seed);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    cmd_i        <= c;
    seed_value_i <= seed;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic word_t pick_seed();
    case ($urandom_range(9))
      0, 1:    return '0;
      2:       return '1;
      3:       return word_t'(1) << $urandom_range(WordW - 1);
      default: return $urandom;
    endcase
  endfunction

  function automatic cmd_e pick_cmd();
    return ($urandom_range(99) < 8) ? CMD_RESEED : CMD_DRAW;
  endfunction

  // Draws on the cleared ring, a zero seed taking the beat count, index wraps,
  // and extreme seeds.
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (3) send_beat(CMD_DRAW, $urandom);
    send_beat(CMD_RESEED, '0);
    repeat (14) send_beat(CMD_DRAW, '1);
    send_beat(CMD_RESEED, '1);
    send_beat(CMD_DRAW, '0);
    send_beat(CMD_RESEED, 32'd1);
    send_beat(CMD_DRAW, '0);
    send_beat(CMD_RESEED, 32'h8000_0000);
    repeat (2) send_beat(CMD_DRAW, '0);
    drain_results();
  endtask

  task automatic test_random_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (PhaseItems) send_beat(pick_cmd(), pick_seed());
    drain_results();
  endtask

  // The receiver holds off long enough that the core fills and stalls its input.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_left  = 300;
    repeat (60) send_beat(pick_cmd(), pick_seed());
    drain_results();
  endtask

  initial begin
    in_valid_i     = 1'b0;
    cmd_i          = CMD_DRAW;
    seed_value_i   = '0;
    out_stall_i    = 1'b0;
    rst_ni         = 1'b0;
    fail_count     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_left  = 0;
    quiet_cycles   = 0;
    gen_cur        = '0;
    gen_partner    = 5'(PartnerStart);
    gen_beats      = '0;
    for (int i = 0; i < RingDepth; i++) gen_ring[i] = '0;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random_phase(0, 0);
    test_random_phase(84, 0);
    test_random_phase(0, 84);
    test_random_phase(10, 10);
    test_backpressure();

    if (expected_words.size() != 0) report_mismatch("missing beats", '0, expected_words[0]);
    if (fail_count == 0) begin
      $display("PASS rotating_lagged_fibonacci_rng_core");
    end else begin
      $display("FAIL rotating_lagged_fibonacci_rng_core");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/rlfr_pkg.sv
hw/rtl/rlfr_alu.sv
hw/rtl/rlfr_ring.sv
hw/rtl/rotating_lagged_fibonacci_rng_core.sv
tb/rotating_lagged_fibonacci_rng_core_tb.sv
